// ===== hdl/assert_macros.svh =====
// Assertion macros for the hall decoder RTL.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/hssd_pkg.sv =====
// Shared types and constants for the hall sensor speed/direction decoder.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hssd_pkg;

  // Field widths
  localparam int HALL_W      = 3;
  localparam int OUT_COUNT_W = 16;
  localparam int SPEED_W     = 26;
  localparam int TICKS_W     = 24;
  localparam int POLES_W     = 7;
  localparam int SCALE_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLE_PAIRS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RPM_SCALE    = 2'd2;

  // Register reset values
  localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST = 24'd10000;
  localparam logic [POLES_W-1:0] POLE_PAIRS_RST   = 7'd7;
  localparam logic [SCALE_W-1:0] RPM_SCALE_RST    = 16'd1000;

  // Input word kinds
  localparam logic OP_HALL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Hall codes that carry no sector
  localparam logic [HALL_W-1:0] HALL_NONE    = 3'd0;
  localparam logic [HALL_W-1:0] HALL_INVALID = 3'd7;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Speed saturation limits (two's complement, 26 bits)
  localparam logic [SPEED_W-1:0] SPEED_MAX = 26'h1FF_FFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 26'h200_0000;

  // Direction step codes
  localparam logic [1:0] STEP_Z = 2'b00;
  localparam logic [1:0] STEP_U = 2'b01;
  localparam logic [1:0] STEP_D = 2'b11;

  // Direction table, [last code][new code]; row 6 kept as specified
  localparam logic [1:0] STEP_TABLE [8][8] = '{
    '{STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z},
    '{STEP_Z, STEP_Z, STEP_U, STEP_Z, STEP_D, STEP_Z, STEP_Z, STEP_Z},
    '{STEP_Z, STEP_D, STEP_Z, STEP_U, STEP_Z, STEP_Z, STEP_Z, STEP_Z},
    '{STEP_Z, STEP_Z, STEP_D, STEP_Z, STEP_Z, STEP_U, STEP_Z, STEP_Z},
    '{STEP_Z, STEP_U, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_D, STEP_Z},
    '{STEP_Z, STEP_Z, STEP_Z, STEP_D, STEP_Z, STEP_Z, STEP_U, STEP_Z},
    '{STEP_Z, STEP_Z, STEP_U, STEP_Z, STEP_D, STEP_Z, STEP_Z, STEP_Z},
    '{STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_Z}
  };

  // Speed scaling setup seen by the back end
  typedef struct packed {
    logic [POLES_W-1:0] pole_pairs;
    logic [SCALE_W-1:0] rpm_scale;
  } speed_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/hssd_queue.sv =====
// Small register FIFO between the front and back of the hall decoder.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module hssd_queue #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign valid   = (fill != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hssd_front.sv =====
// Front end: takes hall/tick words, tracks direction count and window timer.
// Uses hssd_pkg; feeds hssd_queue with {hall, done, count} words.
`timescale 1ns / 1ps
`default_nettype none

module hssd_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              op,
  input  logic [hssd_pkg::HALL_W-1:0]       hall_code,
  input  logic [hssd_pkg::TICKS_W-1:0]      window_ticks,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [COUNT_BITS+3:0]             q_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic [hssd_pkg::HALL_W-1:0]  last_code;
  logic [hssd_pkg::HALL_W-1:0]  last_code_next;
  logic [COUNT_BITS-1:0]        sector_count;
  logic [COUNT_BITS-1:0]        sector_count_next;
  logic [hssd_pkg::TICKS_W-1:0] window_timer;
  logic [hssd_pkg::TICKS_W-1:0] window_timer_next;
  logic [hssd_pkg::TICKS_W-1:0] timer_inc;
  logic [hssd_pkg::TICKS_W-1:0] limit;
  logic [1:0]                   step;
  logic                         code_ok;
  logic                         done;

  assign q_push = push && !q_full;

  // Classify the word and work out the next state
  always_comb begin
    step              = hssd_pkg::STEP_TABLE[last_code][hall_code];
    code_ok           = (hall_code != hssd_pkg::HALL_NONE) &&
                        (hall_code != hssd_pkg::HALL_INVALID);
    timer_inc         = window_timer + hssd_pkg::TICKS_W'(1);
    limit             = (window_ticks == '0) ? hssd_pkg::TICKS_W'(1) : window_ticks;
    last_code_next    = last_code;
    sector_count_next = sector_count;
    window_timer_next = window_timer;
    done              = 1'b0;
    if (op == hssd_pkg::OP_HALL) begin
      if (code_ok) begin
        last_code_next = hall_code;
        // saturating step
        case (step)
          hssd_pkg::STEP_U: begin
            if (sector_count != CNT_MAX) begin
              sector_count_next = sector_count + COUNT_BITS'(1);
            end
          end
          hssd_pkg::STEP_D: begin
            if (sector_count != CNT_MIN) begin
              sector_count_next = sector_count - COUNT_BITS'(1);
            end
          end
          default: ;
        endcase
      end
    end else begin
      if (timer_inc >= limit) begin
        done              = 1'b1;
        window_timer_next = '0;
        sector_count_next = '0;
      end else begin
        window_timer_next = timer_inc;
      end
    end
  end

  // On a closing tick the count field carries the window's count; else the running count
  assign q_data = {last_code_next, done, done ? sector_count : sector_count_next};

  // State update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code    <= '0;
      sector_count <= '0;
      window_timer <= '0;
    end else if (q_push) begin
      last_code    <= last_code_next;
      sector_count <= sector_count_next;
      window_timer <= window_timer_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hssd_back.sv =====
// Back end: turns queued words into results, computing speed on window close.
// Uses hssd_pkg; reads words from hssd_queue and owns the output register.
`timescale 1ns / 1ps
`default_nettype none

module hssd_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_valid,
  input  logic [COUNT_BITS+3:0]                    q_data,
  output logic                                     q_pop,
  input  hssd_pkg::speed_cfg_t                     cfg,
  input  logic                                     pop,
  output logic                                     empty,
  output logic [hssd_pkg::HALL_W-1:0]              hall_state,
  output logic signed [hssd_pkg::OUT_COUNT_W-1:0]  running_count,
  output logic                                     window_done,
  output logic signed [hssd_pkg::OUT_COUNT_W-1:0]  window_count,
  output logic signed [hssd_pkg::SPEED_W-1:0]      speed_rpm,
  output logic                                     busy
);

  localparam int PROD_W = COUNT_BITS + hssd_pkg::SCALE_W;
  localparam int CYC_W  = $clog2(PROD_W + 1);
  localparam int QX_W   = (PROD_W > hssd_pkg::SPEED_W) ? PROD_W : hssd_pkg::SPEED_W + 1;
  localparam int PW     = hssd_pkg::POLES_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                        state;
  logic [COUNT_BITS-1:0]             mag;
  logic                              neg;
  logic [hssd_pkg::HALL_W-1:0]       hall_hold;
  logic [hssd_pkg::OUT_COUNT_W-1:0]  cnt_hold;
  logic [PROD_W-1:0]                 quot;
  logic [PW-1:0]                     rem;
  logic [CYC_W-1:0]                  cyc;
  logic                              out_valid;
  logic [hssd_pkg::OUT_COUNT_W-1:0]  latched_count;
  logic [hssd_pkg::SPEED_W-1:0]      latched_speed;

  logic [hssd_pkg::HALL_W-1:0]       h_hall;
  logic                              h_done;
  logic [COUNT_BITS-1:0]             h_count;
  logic                              slot_free;
  logic                              load_pass;
  logic                              load_win;
  logic [PW-1:0]                     divisor;
  logic [PW:0]                       shifted;
  logic [PW:0]                       trial;
  logic                              fits;
  logic [QX_W-1:0]                   qx;
  logic [hssd_pkg::SPEED_W-1:0]      speed_sat;

  // Head word fields
  assign h_hall  = q_data[COUNT_BITS+3:COUNT_BITS+1];
  assign h_done  = q_data[COUNT_BITS];
  assign h_count = q_data[COUNT_BITS-1:0];

  assign empty     = !out_valid;
  assign busy      = (state != ST_IDLE);
  assign slot_free = !out_valid || pop;
  assign q_pop     = q_valid && (state == ST_IDLE) && (h_done || slot_free);
  assign load_pass = q_pop && !h_done;
  assign load_win  = (state == ST_OUT) && slot_free;

  // One restoring divide step per cycle
  assign divisor = (cfg.pole_pairs == '0) ? PW'(1) : cfg.pole_pairs;
  assign shifted = {rem, quot[PROD_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  // Saturate the signed quotient to the speed range
  always_comb begin
    qx = QX_W'(quot);
    if (neg) begin
      if (qx > QX_W'(hssd_pkg::SPEED_MIN)) begin
        speed_sat = hssd_pkg::SPEED_MIN;
      end else begin
        speed_sat = -qx[hssd_pkg::SPEED_W-1:0];
      end
    end else begin
      if (qx > QX_W'(hssd_pkg::SPEED_MAX)) begin
        speed_sat = hssd_pkg::SPEED_MAX;
      end else begin
        speed_sat = qx[hssd_pkg::SPEED_W-1:0];
      end
    end
  end

  // Sequencer: capture, multiply, divide, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      latched_count <= '0;
      latched_speed <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop && h_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cyc == CYC_W'(1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_win) begin
        latched_count <= cnt_hold;
        latched_speed <= speed_sat;
      end
      if (load_pass || load_win) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath of the speed computation
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop && h_done) begin
          neg       <= h_count[COUNT_BITS-1];
          mag       <= h_count[COUNT_BITS-1] ? -h_count : h_count;
          hall_hold <= h_hall;
          cnt_hold  <= hssd_pkg::OUT_COUNT_W'($signed(h_count));
        end
      end
      ST_MUL: begin
        quot <= PROD_W'(mag) * PROD_W'(cfg.rpm_scale);
        rem  <= '0;
        cyc  <= CYC_W'(PROD_W);
      end
      ST_DIV: begin
        quot <= {quot[PROD_W-2:0], fits};
        rem  <= fits ? trial[PW-1:0] : shifted[PW-1:0];
        cyc  <= cyc - CYC_W'(1);
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_pass) begin
      hall_state    <= h_hall;
      running_count <= hssd_pkg::OUT_COUNT_W'($signed(h_count));
      window_done   <= 1'b0;
      window_count  <= latched_count;
      speed_rpm     <= latched_speed;
    end else if (load_win) begin
      hall_state    <= hall_hold;
      running_count <= '0;
      window_done   <= 1'b1;
      window_count  <= cnt_hold;
      speed_rpm     <= speed_sat;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hall_sensor_speed_direction_decoder_unit.sv =====
// Hall sensor speed/direction decoder: top level with configuration registers.
// Uses hssd_pkg, hssd_front, hssd_queue, hssd_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Each input word is a hall code sample (op = 0) or one time tick (op = 1) and
// yields exactly one result word, in order. The front end accepts a word in
// every cycle while the 4-word internal queue has room (full low), so hall
// edges and ticks may arrive back to back. Words that do not close a window
// leave the back end at one per cycle while it is idle and its result slot is
// free. A tick that closes a window keeps the back end busy through a capture,
// one multiply by rpm_scale, one restoring divide step per product bit
// (COUNT_BITS + 16) against pole_pairs, and a delivery that waits for a free
// result slot. Words behind it wait in the queue, then drain at one per cycle
// while the slot is free. Configuration is written through cfg_valid/cfg_ready
// (always ready) and must only change while no word is in flight.
module hall_sensor_speed_direction_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // input queue side
  input  logic                                     push,
  output logic                                     full,
  input  logic                                     op,
  input  logic [hssd_pkg::HALL_W-1:0]              hall_code,
  // result queue side
  output logic                                     empty,
  input  logic                                     pop,
  output logic [hssd_pkg::HALL_W-1:0]              hall_state,
  output logic signed [hssd_pkg::OUT_COUNT_W-1:0]  running_count,
  output logic                                     window_done,
  output logic signed [hssd_pkg::OUT_COUNT_W-1:0]  window_count,
  output logic signed [hssd_pkg::SPEED_W-1:0]      speed_rpm,
  // configuration
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [hssd_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [hssd_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int ENTRY_W = COUNT_BITS + 4;

  logic [hssd_pkg::TICKS_W-1:0] window_ticks;
  logic [hssd_pkg::POLES_W-1:0] pole_pairs;
  logic [hssd_pkg::SCALE_W-1:0] rpm_scale;
  hssd_pkg::speed_cfg_t         speed_cfg;

  logic               q_push;
  logic               q_full;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_head_done;
  logic               be_busy;

  assign cfg_ready   = 1'b1;
  assign full        = q_full;
  assign q_head_done = q_rdata[COUNT_BITS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= hssd_pkg::WINDOW_TICKS_RST;
      pole_pairs   <= hssd_pkg::POLE_PAIRS_RST;
      rpm_scale    <= hssd_pkg::RPM_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hssd_pkg::REG_WINDOW_TICKS: window_ticks <= cfg_data;
        hssd_pkg::REG_POLE_PAIRS:   pole_pairs   <= cfg_data[hssd_pkg::POLES_W-1:0];
        hssd_pkg::REG_RPM_SCALE:    rpm_scale    <= cfg_data[hssd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign speed_cfg.pole_pairs = pole_pairs;
  assign speed_cfg.rpm_scale  = rpm_scale;

  // Front end
  hssd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .op           (op),
    .hall_code    (hall_code),
    .window_ticks (window_ticks),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // Decoupling queue
  hssd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (hssd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // Back end
  hssd_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .cfg           (speed_cfg),
    .pop           (pop),
    .empty         (empty),
    .hall_state    (hall_state),
    .running_count (running_count),
    .window_done   (window_done),
    .window_count  (window_count),
    .speed_rpm     (speed_rpm),
    .busy          (be_busy)
  );

  // Checks
  `ASSERT_IMPLIES(a_done_clears_count, !empty && window_done, running_count == 16'sd0)
  `ASSERT_IMPLIES(a_pop_has_word, q_pop, q_valid)
  `ASSERT_NEXT(a_window_starts_back, q_pop && q_head_done, be_busy)

endmodule

`default_nettype wire
